### src/rsi_pkg.sv
// Shared widths, constants and the front-to-back work record for the ray-sphere unit.
// Depends on nothing; every other file of the unit refers to it by scoped names.
package rsi_pkg;

	// Coordinate format: signed fixed point, FRAC_BITS fraction bits.
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int DIR_WIDTH   = FRAC_BITS + 2;
	localparam int RAD_WIDTH   = COORD_WIDTH - 1;

	// Vector from ray origin to sphere center, exact.
	localparam int L_W    = COORD_WIDTH + 1;
	// One term of L.dir and the full dot product.
	localparam int PD_W   = L_W + DIR_WIDTH;
	localparam int DOT_W  = PD_W + 2;
	// tca is L.dir floored to the coordinate format.
	localparam int TCA_W  = DOT_W - FRAC_BITS;
	localparam int TMAG_W = TCA_W;
	// tca magnitude is squared as a low and a high part.
	localparam int TLO_W  = (TMAG_W > 32) ? 32 : TMAG_W - 1;
	localparam int THI_W  = TMAG_W - TLO_W;
	localparam int TSQ_W  = 2 * TMAG_W;
	// Squares of L components, L.L and radius squared.
	localparam int LSQ_W  = 2 * L_W;
	localparam int LL_W   = LSQ_W + 2;
	localparam int RSQ_W  = 2 * RAD_WIDTH;
	// radius^2 - L.L + tca^2, signed.
	localparam int REM_BASE_W = (LL_W > TSQ_W + 1) ? LL_W : TSQ_W + 1;
	localparam int REM_W      = REM_BASE_W + 2;
	// Square root: one result bit per step, two radicand bits per step.
	localparam int ROOT_W  = REM_W / 2;
	localparam int RADIC_W = 2 * ROOT_W;
	// Candidate distances tca - thc and tca + thc, signed.
	localparam int T_W = ((TCA_W > ROOT_W + 1) ? TCA_W : ROOT_W + 1) + 1;

	// Decoupling queue between front and back; depth is a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified ray-sphere test handed from the front to the back.
	typedef struct packed {
		logic                    miss;
		logic signed [TCA_W-1:0] tca;
		logic [RADIC_W-1:0]      radicand;
	} work_t;

endpackage

### src/rsi_ray_if.sv
// Input channel of the ray-sphere unit: one ray and one sphere per beat.
// Depends on rsi_pkg for the field widths.
interface rsi_ray_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [rsi_pkg::COORD_WIDTH-1:0]  orig_x;
	logic signed [rsi_pkg::COORD_WIDTH-1:0]  orig_y;
	logic signed [rsi_pkg::COORD_WIDTH-1:0]  orig_z;
	logic signed [rsi_pkg::DIR_WIDTH-1:0]    dir_x;
	logic signed [rsi_pkg::DIR_WIDTH-1:0]    dir_y;
	logic signed [rsi_pkg::DIR_WIDTH-1:0]    dir_z;
	logic signed [rsi_pkg::COORD_WIDTH-1:0]  center_x;
	logic signed [rsi_pkg::COORD_WIDTH-1:0]  center_y;
	logic signed [rsi_pkg::COORD_WIDTH-1:0]  center_z;
	logic [rsi_pkg::RAD_WIDTH-1:0]           sphere_radius;

	modport source (
		output valid, orig_x, orig_y, orig_z, dir_x, dir_y, dir_z,
		output center_x, center_y, center_z, sphere_radius,
		input  ready
	);

	modport sink (
		input  valid, orig_x, orig_y, orig_z, dir_x, dir_y, dir_z,
		input  center_x, center_y, center_z, sphere_radius,
		output ready
	);
endinterface

### src/rsi_hit_if.sv
// Output channel of the ray-sphere unit: hit flag and distance per beat.
// Depends on rsi_pkg for the distance width.
interface rsi_hit_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [rsi_pkg::RAD_WIDTH-1:0] distance;

	modport source (
		output valid, hit, distance,
		input  ready
	);

	modport sink (
		input  valid, hit, distance,
		output ready
	);
endinterface

### src/rsi_front.sv
// Front pipeline: takes ray beats, forms L, the dot products, tca and r^2 - d2,
// and classifies each test as a miss or a square-root job. Uses rsi_pkg, rsi_ray_if.
module rsi_front (
	input  logic           clk,
	input  logic           arst_n,
	rsi_ray_if.sink        ray,
	output logic           push_valid,
	output rsi_pkg::work_t push_data,
	input  logic           push_ready
);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [rsi_pkg::L_W-1:0]       lx_s1, ly_s1, lz_s1;
	logic signed [rsi_pkg::DIR_WIDTH-1:0] dx_s1, dy_s1, dz_s1;
	logic [rsi_pkg::RAD_WIDTH-1:0]        rad_s1;

	logic signed [rsi_pkg::PD_W-1:0]  pdx_s2, pdy_s2, pdz_s2;
	logic signed [rsi_pkg::LSQ_W-1:0] lsqx_s2, lsqy_s2, lsqz_s2;
	logic [rsi_pkg::RSQ_W-1:0]        rsq_s2, rsq_s3;

	logic signed [rsi_pkg::DOT_W-1:0] dot_s3;
	logic signed [rsi_pkg::LL_W-1:0]  ll_s3;

	logic signed [rsi_pkg::REM_W-1:0] base_s4, base_s5, base_s6;
	logic signed [rsi_pkg::TCA_W-1:0] tca_s4, tca_s5, tca_s6, tca_s7;
	logic [rsi_pkg::TMAG_W-1:0]       tmag_s4;

	logic [2*rsi_pkg::TLO_W-1:0]             lo2_s5;
	logic [rsi_pkg::THI_W+rsi_pkg::TLO_W-1:0] cross_s5;
	logic [2*rsi_pkg::THI_W-1:0]             hi2_s5;

	logic [rsi_pkg::TSQ_W-1:0]        sq_s6;
	logic signed [rsi_pkg::REM_W-1:0] rem_s7;

	logic signed [rsi_pkg::TCA_W-1:0] tca_c;
	logic [rsi_pkg::TLO_W-1:0]        tlo_c;
	logic [rsi_pkg::THI_W-1:0]        thi_c;

	// The whole front holds only when its last stage cannot enter the queue.
	assign en        = !vld_s7 || push_ready;
	assign ray.ready = en;

	// tca is the dot product floored to the coordinate format.
	assign tca_c = dot_s3[rsi_pkg::DOT_W-1:rsi_pkg::FRAC_BITS];
	assign tlo_c = tmag_s4[rsi_pkg::TLO_W-1:0];
	assign thi_c = tmag_s4[rsi_pkg::TMAG_W-1:rsi_pkg::TLO_W];

	// Valid flags of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ray.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Datapath: one multiplier or one wide add between registers.
	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: L = center - origin.
			lx_s1  <= rsi_pkg::L_W'(ray.center_x) - rsi_pkg::L_W'(ray.orig_x);
			ly_s1  <= rsi_pkg::L_W'(ray.center_y) - rsi_pkg::L_W'(ray.orig_y);
			lz_s1  <= rsi_pkg::L_W'(ray.center_z) - rsi_pkg::L_W'(ray.orig_z);
			dx_s1  <= ray.dir_x;
			dy_s1  <= ray.dir_y;
			dz_s1  <= ray.dir_z;
			rad_s1 <= ray.sphere_radius;

			// Stage 2: all products.
			pdx_s2  <= lx_s1 * dx_s1;
			pdy_s2  <= ly_s1 * dy_s1;
			pdz_s2  <= lz_s1 * dz_s1;
			lsqx_s2 <= lx_s1 * lx_s1;
			lsqy_s2 <= ly_s1 * ly_s1;
			lsqz_s2 <= lz_s1 * lz_s1;
			rsq_s2  <= rad_s1 * rad_s1;

			// Stage 3: L.dir and L.L.
			dot_s3 <= rsi_pkg::DOT_W'(pdx_s2) + rsi_pkg::DOT_W'(pdy_s2)
				+ rsi_pkg::DOT_W'(pdz_s2);
			ll_s3  <= rsi_pkg::LL_W'(lsqx_s2) + rsi_pkg::LL_W'(lsqy_s2)
				+ rsi_pkg::LL_W'(lsqz_s2);
			rsq_s3 <= rsq_s2;

			// Stage 4: radius^2 - L.L and the magnitude of tca.
			base_s4 <= rsi_pkg::REM_W'($signed({1'b0, rsq_s3})) - rsi_pkg::REM_W'(ll_s3);
			tca_s4  <= tca_c;
			tmag_s4 <= tca_c[rsi_pkg::TCA_W-1] ? rsi_pkg::TMAG_W'(-tca_c)
				: rsi_pkg::TMAG_W'(tca_c);

			// Stage 5: partial products of tca squared.
			lo2_s5   <= tlo_c * tlo_c;
			cross_s5 <= thi_c * tlo_c;
			hi2_s5   <= thi_c * thi_c;
			base_s5  <= base_s4;
			tca_s5   <= tca_s4;

			// Stage 6: tca squared. High and low squares do not overlap.
			sq_s6   <= {hi2_s5, lo2_s5}
				+ (rsi_pkg::TSQ_W'(cross_s5) << (rsi_pkg::TLO_W + 1));
			base_s6 <= base_s5;
			tca_s6  <= tca_s5;

			// Stage 7: r^2 - d2 = r^2 - L.L + tca^2.
			rem_s7 <= base_s6 + rsi_pkg::REM_W'($signed({1'b0, sq_s6}));
			tca_s7 <= tca_s6;
		end
	end

	// Classification: a negative r^2 - d2 is a miss, otherwise a root job.
	always_comb begin
		push_valid         = vld_s7;
		push_data.miss     = rem_s7[rsi_pkg::REM_W-1];
		push_data.tca      = tca_s7;
		push_data.radicand = rsi_pkg::RADIC_W'(rem_s7[rsi_pkg::REM_W-2:0]);
	end

	// A beat taken on the ray channel enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && ray.ready |=> vld_s1)
		else $error("accepted ray beat did not reach the first front stage");

	// A classified test blocked by a full queue waits unchanged.
	a_blocked_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && !push_ready |=> vld_s7 && $stable(rem_s7) && $stable(tca_s7))
		else $error("blocked front output changed before entering the queue");

endmodule

### src/rsi_queue.sv
// Short queue between the front and back pipelines of the ray-sphere unit.
// Depends on rsi_pkg for the work record and the queue depth.
module rsi_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  rsi_pkg::work_t push_data,
	output logic           push_ready,
	output logic           pop_valid,
	output rsi_pkg::work_t pop_data,
	input  logic           pop_ready
);

	rsi_pkg::work_t              mem_q [0:rsi_pkg::QUEUE_DEPTH-1];
	logic [rsi_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [rsi_pkg::QCNT_W-1:0]  count_q;
	logic                        push, pop;

	assign push_ready = count_q != rsi_pkg::QCNT_W'(rsi_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers and fill count; pointers wrap at the power-of-two depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + rsi_pkg::QCNT_W'(1))
		else $error("queue count did not rise on a lone push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - rsi_pkg::QCNT_W'(1))
		else $error("queue count did not fall on a lone pop");

endmodule

### src/rsi_back.sv
// Back pipeline: square root one bit per stage, then picks the nearer
// non-negative distance and saturates it. Uses rsi_pkg and rsi_hit_if.
module rsi_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  rsi_pkg::work_t pop_data,
	output logic           pop_ready,
	rsi_hit_if.source      result
);

	typedef struct packed {
		logic                            miss;
		logic signed [rsi_pkg::TCA_W-1:0] tca;
		logic [rsi_pkg::RADIC_W-1:0]     radic;
		logic [rsi_pkg::ROOT_W:0]        part;
		logic [rsi_pkg::ROOT_W-1:0]      root;
	} root_step_t;

	// One restoring square-root step: brings down two radicand bits and
	// decides one root bit.
	function automatic root_step_t root_step(input root_step_t s);
		logic [rsi_pkg::ROOT_W+2:0] trial_rem;
		logic [rsi_pkg::ROOT_W+2:0] trial;
		logic [rsi_pkg::ROOT_W+2:0] diff;
		root_step_t                 n;
		trial_rem = {s.part, s.radic[rsi_pkg::RADIC_W-1 -: 2]};
		trial     = {1'b0, s.root, 2'b01};
		diff      = trial_rem - trial;
		n         = s;
		n.radic   = {s.radic[rsi_pkg::RADIC_W-3:0], 2'b00};
		if (trial_rem >= trial) begin
			n.part = diff[rsi_pkg::ROOT_W:0];
			n.root = {s.root[rsi_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			n.part = trial_rem[rsi_pkg::ROOT_W:0];
			n.root = {s.root[rsi_pkg::ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

	logic                         en;
	logic [rsi_pkg::ROOT_W:0]     step_vld_q;
	root_step_t                   step_q [0:rsi_pkg::ROOT_W];
	root_step_t                   init_c;
	root_step_t                   fin_c;

	logic                         sel_vld_s1, sel_miss_s1;
	logic signed [rsi_pkg::T_W-1:0] tminus_s1, tplus_s1;
	logic signed [rsi_pkg::T_W-1:0] tca_ext_c, thc_ext_c, pick_c;
	logic                         hit_c, over_c;
	logic [rsi_pkg::RAD_WIDTH-1:0] dist_c;

	logic                          out_vld_q, hit_q;
	logic [rsi_pkg::RAD_WIDTH-1:0] dist_q;

	// The back advances whenever the output register is free or being taken.
	assign en        = !out_vld_q || result.ready;
	assign pop_ready = en;

	// First root stage starts from the queue head with an empty remainder.
	always_comb begin
		init_c.miss  = pop_data.miss;
		init_c.tca   = pop_data.tca;
		init_c.radic = pop_data.radicand;
		init_c.part  = '0;
		init_c.root  = '0;
	end

	// Valid flags of the root stages, the select stage and the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_vld_q <= '0;
			sel_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (en) begin
			step_vld_q <= {step_vld_q[rsi_pkg::ROOT_W-1:0], pop_valid};
			sel_vld_s1 <= step_vld_q[rsi_pkg::ROOT_W];
			out_vld_q  <= sel_vld_s1;
		end
	end

	// Candidate distances from the finished root.
	assign fin_c     = step_q[rsi_pkg::ROOT_W];
	assign tca_ext_c = rsi_pkg::T_W'(fin_c.tca);
	assign thc_ext_c = rsi_pkg::T_W'({1'b0, fin_c.root});

	// Nearer non-negative candidate, then saturation to the output range.
	always_comb begin
		pick_c = tminus_s1[rsi_pkg::T_W-1] ? tplus_s1 : tminus_s1;
		hit_c  = !sel_miss_s1 && !pick_c[rsi_pkg::T_W-1];
		over_c = |pick_c[rsi_pkg::T_W-2:rsi_pkg::RAD_WIDTH];
		if (!hit_c) begin
			dist_c = '0;
		end else if (over_c) begin
			dist_c = '1;
		end else begin
			dist_c = pick_c[rsi_pkg::RAD_WIDTH-1:0];
		end
	end

	// Root stages, select stage and output register.
	always_ff @(posedge clk) begin
		if (en) begin
			step_q[0] <= init_c;
			for (int k = 0; k < rsi_pkg::ROOT_W; k++) begin
				step_q[k+1] <= root_step(step_q[k]);
			end
			sel_miss_s1 <= fin_c.miss;
			tminus_s1   <= tca_ext_c - thc_ext_c;
			tplus_s1    <= tca_ext_c + thc_ext_c;
			hit_q       <= hit_c;
			dist_q      <= dist_c;
		end
	end

	assign result.valid    = out_vld_q;
	assign result.hit      = hit_q;
	assign result.distance = dist_q;

	// While the output is stalled no root stage may move.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(step_vld_q) && $stable(sel_vld_s1))
		else $error("root pipeline moved while the output was stalled");

	// A miss never carries a distance.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !hit_q |-> dist_q == '0)
		else $error("miss result carries a nonzero distance");

endmodule

### src/ray_sphere_intersect.sv
// Ray-sphere intersection unit, geometric method, signed Q16.16 fixed point.
// Throughput is one ray beat per clock while the output is not stalled; each result beat
// is offered once its ray beat has passed 7 front stages, 1 queue slot, 1 + 38 square-root
// stages (one per root bit) and 2 select/output stages. Output stalls back up through a
// 4-entry queue to the front. Reset is asynchronous, active low, and clears all
// valid flags and queue pointers; data registers are not reset.
module ray_sphere_intersect (
	input  logic      clk,
	input  logic      arst_n,
	rsi_ray_if.sink   ray,
	rsi_hit_if.source result
);

	logic           front_valid, front_ready;
	rsi_pkg::work_t front_data;
	logic           back_valid, back_ready;
	rsi_pkg::work_t back_data;

	// Front: dot products and classification.
	rsi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ray        (ray),
		.push_valid (front_valid),
		.push_data  (front_data),
		.push_ready (front_ready)
	);

	// Decoupling queue.
	rsi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_data  (front_data),
		.push_ready (front_ready),
		.pop_valid  (back_valid),
		.pop_data   (back_data),
		.pop_ready  (back_ready)
	);

	// Back: square root and distance selection.
	rsi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (back_valid),
		.pop_data  (back_data),
		.pop_ready (back_ready),
		.result    (result)
	);

endmodule

### test/tb_ray_sphere_intersect.sv
// Self-checking testbench for ray_sphere_intersect: directed and random ray beats,
// with a bit-exact fixed-point intersection predictor and an in-order scoreboard.
// Depends on rsi_pkg, rsi_ray_if, rsi_hit_if and the ray_sphere_intersect RTL.
module tb_ray_sphere_intersect;
	import rsi_pkg::*;

	localparam int  HOLD_CYCLES  = 400;
	localparam int  DRAIN_CYCLES = 60;
	localparam int  CYCLE_LIMIT  = 200000;
	localparam int  Q_ONE        = 1 << FRAC_BITS;
	localparam logic [RAD_WIDTH-1:0] DIST_MAX = {RAD_WIDTH{1'b1}};

	// One ray and one sphere, as carried by an input beat.
	typedef struct {
		logic signed [COORD_WIDTH-1:0] ox, oy, oz;
		logic signed [DIR_WIDTH-1:0]   dx, dy, dz;
		logic signed [COORD_WIDTH-1:0] cx, cy, cz;
		logic [RAD_WIDTH-1:0]          rad;
	} ray_t;

	// One intersection result, as carried by an output beat.
	typedef struct packed {
		logic                 hit;
		logic [RAD_WIDTH-1:0] distance;
	} hit_t;

	// Holds the predicted results of accepted rays, oldest first.
	class hit_scoreboard;
		hit_t        expected_hits[$];
		int unsigned fail_count = 0;

		// Geometric ray-sphere test, exact in wide signed arithmetic.
		function hit_t predict_hit(ray_t r);
			logic signed [127:0] lx, ly, lz, dx, dy, dz, rad;
			logic signed [127:0] dot, tca, ll, rem, root, cand, t0;
			hit_t res;
			lx  = 128'(r.cx);
			lx  = lx - 128'(r.ox);
			ly  = 128'(r.cy);
			ly  = ly - 128'(r.oy);
			lz  = 128'(r.cz);
			lz  = lz - 128'(r.oz);
			dx  = 128'(r.dx);
			dy  = 128'(r.dy);
			dz  = 128'(r.dz);
			rad = 128'(r.rad);
			res = '0;
			dot = lx * dx + ly * dy + lz * dz;
			tca = dot >>> FRAC_BITS;
			ll  = lx * lx + ly * ly + lz * lz;
			// radius^2 - d2, where d2 = L.L - tca^2 may be negative.
			rem = rad * rad - ll + tca * tca;
			if (rem < 0)
				return res;
			// Floored square root, one bit at a time from the top.
			root = '0;
			for (int b = 63; b >= 0; b--) begin
				cand = root | (128'sd1 <<< b);
				if (cand * cand <= rem)
					root = cand;
			end
			t0 = tca - root;
			if (t0 < 0)
				t0 = tca + root;
			if (t0 < 0)
				return res;
			res.hit = 1'b1;
			if (t0 > $signed({97'd0, DIST_MAX}))
				res.distance = DIST_MAX;
			else
				res.distance = t0[RAD_WIDTH-1:0];
			return res;
		endfunction

		function void note_ray(ray_t r);
			expected_hits.insert(expected_hits.size(), predict_hit(r));
		endfunction

		function void check_result(logic hit, logic [RAD_WIDTH-1:0] distance);
			hit_t want;
			if (expected_hits.size() == 0) begin
				$display("%0t: result beat with no ray waiting, actual hit %0b distance %0d",
					$time, hit, distance);
				fail_count++;
				return;
			end
			want = expected_hits.pop_front();
			if (hit !== want.hit) begin
				$display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, hit);
				fail_count++;
			end
			if (distance !== want.distance) begin
				$display("%0t: distance mismatch, expected %0d, actual %0d",
					$time, want.distance, distance);
				fail_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   hold_request = 1'b0;
	int unsigned cycle_count = 0;
	ray_t ray_queue[$];
	hit_scoreboard sb;

	rsi_ray_if ray_ch();
	rsi_hit_if hit_ch();

	ray_sphere_intersect u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.ray    (ray_ch),
		.result (hit_ch)
	);

	always #5 clk = ~clk;

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Check every accepted result beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && hit_ch.valid && hit_ch.ready)
			sb.check_result(hit_ch.hit, hit_ch.distance);
	end

	function automatic ray_t make_ray(longint ox, longint oy, longint oz, longint dx,
			longint dy, longint dz, longint cx, longint cy, longint cz, longint rad);
		ray_t r;
		r.ox  = COORD_WIDTH'(ox);
		r.oy  = COORD_WIDTH'(oy);
		r.oz  = COORD_WIDTH'(oz);
		r.dx  = DIR_WIDTH'(dx);
		r.dy  = DIR_WIDTH'(dy);
		r.dz  = DIR_WIDTH'(dz);
		r.cx  = COORD_WIDTH'(cx);
		r.cy  = COORD_WIDTH'(cy);
		r.cz  = COORD_WIDTH'(cz);
		r.rad = RAD_WIDTH'(rad);
		return r;
	endfunction

	// Append one ray to the list waiting to be sent.
	function automatic void add_ray(input ray_t r);
		ray_queue.insert(ray_queue.size(), r);
	endfunction

	function automatic logic [COORD_WIDTH-1:0] corner_coord();
		case ($urandom_range(0, 3))
			0: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
			1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DIR_WIDTH-1:0] corner_dir();
		case ($urandom_range(0, 3))
			0: return DIR_WIDTH'(-Q_ONE);
			1: return DIR_WIDTH'(Q_ONE);
			2: return '0;
			default: return DIR_WIDTH'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
		endcase
	endfunction

	// Drive one ray beat and hold it until the block takes it.
	task automatic send_ray(input ray_t r);
		ray_ch.valid         <= 1'b1;
		ray_ch.orig_x        <= r.ox;
		ray_ch.orig_y        <= r.oy;
		ray_ch.orig_z        <= r.oz;
		ray_ch.dir_x         <= r.dx;
		ray_ch.dir_y         <= r.dy;
		ray_ch.dir_z         <= r.dz;
		ray_ch.center_x      <= r.cx;
		ray_ch.center_y      <= r.cy;
		ray_ch.center_z      <= r.cz;
		ray_ch.sphere_radius <= r.rad;
		do @(posedge clk); while (!ray_ch.ready);
		sb.note_ray(r);
	endtask

	// Send every queued ray in bursts of random length with random gaps.
	task automatic play_rays();
		int burst;
		int gap;
		burst = 0;
		while (ray_queue.size() > 0) begin
			if (burst == 0) begin
				burst = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					ray_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send_ray(ray_queue.pop_front());
			burst--;
		end
	endtask

	// Random rays: mostly scenes built around the ray, some full-range noise and corners.
	task automatic queue_random_rays(input int count);
		ray_t   r;
		int     kind;
		int     shift;
		longint ox, oy, oz, t;
		repeat (count) begin
			kind = $urandom_range(0, 9);
			r.dx = DIR_WIDTH'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
			r.dy = DIR_WIDTH'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
			r.dz = DIR_WIDTH'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
			if (kind <= 1) begin
				r.ox  = $urandom;
				r.oy  = $urandom;
				r.oz  = $urandom;
				r.cx  = $urandom;
				r.cy  = $urandom;
				r.cz  = $urandom;
				r.rad = RAD_WIDTH'($urandom);
			end else if (kind == 9) begin
				r.ox  = corner_coord();
				r.oy  = corner_coord();
				r.oz  = corner_coord();
				r.dx  = corner_dir();
				r.dy  = corner_dir();
				r.dz  = corner_dir();
				r.cx  = corner_coord();
				r.cy  = corner_coord();
				r.cz  = corner_coord();
				case ($urandom_range(0, 2))
					0: r.rad = '0;
					1: r.rad = DIST_MAX;
					default: r.rad = RAD_WIDTH'($urandom);
				endcase
			end else begin
				// Center placed near the ray line at a random signed distance.
				shift = $urandom_range(3, 14);
				ox = longint'($signed($urandom)) >>> shift;
				oy = longint'($signed($urandom)) >>> shift;
				oz = longint'($signed($urandom)) >>> shift;
				t  = longint'($signed($urandom)) >>> shift;
				r.ox = COORD_WIDTH'(ox);
				r.oy = COORD_WIDTH'(oy);
				r.oz = COORD_WIDTH'(oz);
				r.cx = COORD_WIDTH'(ox + ((t * r.dx) >>> FRAC_BITS)
					+ (longint'($signed($urandom)) >>> (shift + 3)));
				r.cy = COORD_WIDTH'(oy + ((t * r.dy) >>> FRAC_BITS)
					+ (longint'($signed($urandom)) >>> (shift + 3)));
				r.cz = COORD_WIDTH'(oz + ((t * r.dz) >>> FRAC_BITS)
					+ (longint'($signed($urandom)) >>> (shift + 3)));
				r.rad = RAD_WIDTH'($urandom >> (shift + $urandom_range(0, 2)));
			end
			add_ray(r);
		end
	endtask

	// Receiver: ready follows changing patterns, with one long hold-off on request.
	initial begin
		int style;
		int span;
		hit_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			style = $urandom_range(0, 3);
			span  = $urandom_range(10, 60);
			repeat (span) begin
				@(posedge clk);
				if (hold_request) begin
					hit_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_request = 1'b0;
				end
				case (style)
					0: hit_ch.ready <= 1'b1;
					1: hit_ch.ready <= 1'($urandom_range(0, 1));
					2: hit_ch.ready <= ($urandom_range(0, 7) != 0);
					default: hit_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Stimulus, drain and verdict.
	initial begin
		sb = new();
		arst_n               <= 1'b0;
		ray_ch.valid         <= 1'b0;
		ray_ch.orig_x        <= '0;
		ray_ch.orig_y        <= '0;
		ray_ch.orig_z        <= '0;
		ray_ch.dir_x         <= '0;
		ray_ch.dir_y         <= '0;
		ray_ch.dir_z         <= '0;
		ray_ch.center_x      <= '0;
		ray_ch.center_y      <= '0;
		ray_ch.center_z      <= '0;
		ray_ch.sphere_radius <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Degenerate ray at the center of a point sphere: hit at zero distance.
		add_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Origin on the sphere surface, pointing inward: hit at zero distance.
		add_ray(make_ray(0, 0, 0, Q_ONE, 0, 0, 5 * Q_ONE, 0, 0, 5 * Q_ONE));
		// Plain hit in front of the origin.
		add_ray(make_ray(0, 0, 0, Q_ONE, 0, 0, 10 * Q_ONE, 0, 0, 2 * Q_ONE));
		// Tangent ray, and the same ray just past the tangent.
		add_ray(make_ray(0, 0, 0, Q_ONE, 0, 0, 10 * Q_ONE, 2 * Q_ONE, 0,
			2 * Q_ONE));
		add_ray(make_ray(0, 0, 0, Q_ONE, 0, 0, 10 * Q_ONE, 2 * Q_ONE, 0,
			2 * Q_ONE - 1));
		// Origin inside the sphere: the far intersection is taken.
		add_ray(make_ray(0, 0, 0, Q_ONE, 0, 0, Q_ONE, 0, 0, 5 * Q_ONE));
		// Sphere behind the origin: miss.
		add_ray(make_ray(0, 0, 0, Q_ONE, 0, 0, -10 * Q_ONE, 0, 0, 2 * Q_ONE));
		// Non-unit direction that makes d2 negative.
		add_ray(make_ray(0, 0, 0, Q_ONE, Q_ONE, 0, 10 * Q_ONE, 10 * Q_ONE, 0,
			Q_ONE / 2));
		add_ray(make_ray(Q_ONE, -Q_ONE, 3, -Q_ONE, -Q_ONE, -Q_ONE,
			-20 * Q_ONE, -22 * Q_ONE, -20 * Q_ONE, 3 * Q_ONE));
		// Far sphere: the distance saturates.
		add_ray(make_ray(-2147483648, 0, 0, Q_ONE, 0, 0, 2147483647, 0, 0,
			Q_ONE));
		add_ray(make_ray(2147483647, 0, 0, -Q_ONE, 0, 0, -2147483648, 0, 0,
			2147483647));
		// Field extremes.
		add_ray(make_ray(2147483647, 2147483647, 2147483647, Q_ONE, Q_ONE, Q_ONE,
			2147483647, 2147483647, 2147483647, 2147483647));
		add_ray(make_ray(-2147483648, -2147483648, -2147483648, -Q_ONE, -Q_ONE,
			-Q_ONE, -2147483648, -2147483648, -2147483648, 0));
		add_ray(make_ray(2147483647, -2147483648, 2147483647, -Q_ONE, Q_ONE,
			-Q_ONE, -2147483648, 2147483647, -2147483648, 2147483647));
		// Largest radius around the origin: distance equals the radius.
		add_ray(make_ray(0, 0, 0, 0, 0, Q_ONE, 0, 0, 0, 2147483647));
		add_ray(make_ray(0, 0, 0, 0, -Q_ONE, 0, 0, -7 * Q_ONE, 0, Q_ONE));
		// Alternating bit patterns.
		add_ray(make_ray(32'h55555555, 32'h55555555, 32'h55555555, 43690,
			-43691, 43690, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 31'h55555555));
		add_ray(make_ray(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, -43691,
			43690, -43691, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 31'h2AAAAAAA));
		play_rays();

		// Random part, with the long receiver hold-off part way through.
		queue_random_rays(300);
		play_rays();
		hold_request = 1'b1;
		queue_random_rays(500);
		play_rays();
		ray_ch.valid <= 1'b0;

		while (sb.expected_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

### files.f
src/rsi_pkg.sv
src/rsi_ray_if.sv
src/rsi_hit_if.sv
src/rsi_front.sv
src/rsi_queue.sv
src/rsi_back.sv
src/ray_sphere_intersect.sv
test/tb_ray_sphere_intersect.sv
